// ----- hw/rtl/clkpr_pkg.sv -----
package clkpr_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_SCAN,
      ST_HAND,
      ST_FIN
   } state_type;

   // Item kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_HAND  = 2'd1;
   localparam logic [1:0] KIND_EVICT = 2'd2;

   // Configuration register indexes
   localparam int         CSR_INDEX_W = 1;
   localparam logic [0:0] CSR_MODE    = 1'b0;
   localparam logic [0:0] CSR_FRAMES  = 1'b1;

   // Replacement modes
   localparam logic MODE_CLOCK    = 1'b0;
   localparam logic MODE_MODIFIED = 1'b1;

   // Frames scanned after reset
   localparam int FRAMES_RESET = 64;

endpackage

// ----- hw/rtl/clock_page_replacement_per_process_unit.sv -----
// Frame write, hand set, spare kind: ST_FIN loads the result register after the beat.
// Victim search (N = frames scanned, H = hand, one frame read a cycle on one port):
// ST_MOD reduces H below N; with no victim, ST_SCAN reads 2*N (plain) or 4*N (modified)
// frames; after a victim, ST_HAND reads up to N - 1 more frames in search of the new hand.
// A new request is taken the cycle after the result register loads; a stalled result
// holds the sequencer. Reset clears hands and control registers, then sweeps the frame table.
module clock_page_replacement_per_process_unit #(
   parameter int FRAME_COUNT   = 64,
   parameter int PROCESS_COUNT = 16,
   parameter int PAGE_BITS     = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [((PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1)-1:0] req_process_id,
   input  logic [$clog2(FRAME_COUNT)-1:0]      req_frame_index,
   input  logic                                req_reserved_flag,
   input  logic                                req_page_valid,
   input  logic [PAGE_BITS-1:0]                req_page_number,
   input  logic                                req_present_flag,
   input  logic                                req_use_flag,
   input  logic                                req_dirty_flag,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [$clog2(FRAME_COUNT)-1:0]      rsp_victim_frame,
   output logic [PAGE_BITS-1:0]                rsp_victim_page,
   output logic                                rsp_victim_found,
   output logic                                rsp_needs_writeback,
   output logic [$clog2(FRAME_COUNT)-1:0]      rsp_hand_after,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [clkpr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [$clog2(FRAME_COUNT + 1)-1:0]  csr_data
);

   localparam int FW = $clog2(FRAME_COUNT);
   localparam int NW = $clog2(FRAME_COUNT + 1);
   localparam int PW = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
   localparam int CW = $clog2(4 * FRAME_COUNT + 1);
   localparam int FIU_RESET = (clkpr_pkg::FRAMES_RESET > FRAME_COUNT) ?
                              FRAME_COUNT : clkpr_pkg::FRAMES_RESET;

   typedef struct packed {
      logic                 reserved;
      logic [PW-1:0]        owner;
      logic                 valid;
      logic [PAGE_BITS-1:0] page;
      logic                 present;
      logic                 used;
      logic                 dirty;
   } entry_type;

   // Frame table
   entry_type frame_mem [FRAME_COUNT];

   logic                 mem_we;
   logic [FW-1:0]        mem_waddr;
   entry_type            mem_wdata;
   logic [FW-1:0]        mem_raddr;
   entry_type            rdata_ff;
   logic                 fwd_hit_ff;
   entry_type            fwd_data_ff;

   clkpr_pkg::state_type state_ff, state_in;
   logic                 mode_ff, mode_in;
   logic [NW-1:0]        fiu_ff, fiu_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [PW-1:0]        pid_ff, pid_in;
   logic                 pid_ok_ff, pid_ok_in;
   logic [FW-1:0]        hand_ff [PROCESS_COUNT];
   logic [FW-1:0]        hand_in [PROCESS_COUNT];
   logic [FW-1:0]        h_ff, h_in;
   logic [FW-1:0]        clr_ff, clr_in;
   logic [FW-1:0]        iss_pos_ff, iss_pos_in;
   logic [FW-1:0]        iss_idx_ff, iss_idx_in;
   logic [1:0]           iss_pass_ff, iss_pass_in;
   logic [CW-1:0]        iss_left_ff, iss_left_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic [FW-1:0]        ev_pos_ff, ev_pos_in;
   logic [1:0]           ev_pass_ff, ev_pass_in;
   logic                 ev_last_ff, ev_last_in;
   logic [FW-1:0]        res_frame_ff, res_frame_in;
   logic [PAGE_BITS-1:0] res_page_ff, res_page_in;
   logic                 res_found_ff, res_found_in;
   logic                 res_wb_ff, res_wb_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]        rsp_frame_ff, rsp_frame_in;
   logic [PAGE_BITS-1:0] rsp_page_ff, rsp_page_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic                 rsp_wb_ff, rsp_wb_in;
   logic [FW-1:0]        rsp_hand_ff, rsp_hand_in;

   logic                 req_beat;
   logic                 req_pid_ok;
   logic [NW-1:0]        fiu_clamped;
   logic [NW-1:0]        iss_pos_inc;
   logic [NW-1:0]        iss_idx_inc;
   logic [NW-1:0]        ev_pos_inc;
   logic [FW-1:0]        iss_pos_wrap;
   logic [FW-1:0]        iss_idx_wrap;
   logic [FW-1:0]        ev_pos_wrap;
   entry_type            ent;
   logic                 elig;
   logic                 take;
   logic                 clear_use;
   logic                 hand_hit;

   assign req_stall           = (state_ff != clkpr_pkg::ST_IDLE);
   assign req_beat            = req_valid && !req_stall;
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_victim_frame    = rsp_frame_ff;
   assign rsp_victim_page     = rsp_page_ff;
   assign rsp_victim_found    = rsp_found_ff;
   assign rsp_needs_writeback = rsp_wb_ff;
   assign rsp_hand_after      = rsp_hand_ff;

   assign req_pid_ok = (32'(req_process_id) < 32'(PROCESS_COUNT));

   // Clamp the scan length to 1..FRAME_COUNT
   always_comb begin
      if (fiu_ff == '0) begin
         fiu_clamped = NW'(1);
      end else if (32'(fiu_ff) > 32'(FRAME_COUNT)) begin
         fiu_clamped = NW'(FRAME_COUNT);
      end else begin
         fiu_clamped = fiu_ff;
      end
   end

   // Wrapping increments at the scan length
   assign iss_pos_inc  = NW'(iss_pos_ff) + NW'(1);
   assign iss_idx_inc  = NW'(iss_idx_ff) + NW'(1);
   assign ev_pos_inc   = NW'(ev_pos_ff) + NW'(1);
   assign iss_pos_wrap = (iss_pos_inc == n_ff) ? '0 : FW'(iss_pos_inc);
   assign iss_idx_wrap = (iss_idx_inc == n_ff) ? '0 : FW'(iss_idx_inc);
   assign ev_pos_wrap  = (ev_pos_inc == n_ff) ? '0 : FW'(ev_pos_inc);

   // Evaluate the frame read last cycle, with the write of that cycle forwarded
   assign ent  = fwd_hit_ff ? fwd_data_ff : rdata_ff;
   assign elig = ent.valid && (ent.owner == pid_ff);
   assign take = elig && !ent.used &&
                 ((mode_ff == clkpr_pkg::MODE_CLOCK) ||
                  (ev_pass_ff[0] ? ent.dirty : !ent.dirty));
   assign clear_use = elig && ent.used &&
                      ((mode_ff == clkpr_pkg::MODE_CLOCK) || ev_pass_ff[0]);
   assign hand_hit  = elig && ent.reserved && ent.present;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      fiu_in       = fiu_ff;
      n_in         = n_ff;
      pid_in       = pid_ff;
      pid_ok_in    = pid_ok_ff;
      hand_in      = hand_ff;
      h_in         = h_ff;
      clr_in       = clr_ff;
      iss_pos_in   = iss_pos_ff;
      iss_idx_in   = iss_idx_ff;
      iss_pass_in  = iss_pass_ff;
      iss_left_in  = iss_left_ff;
      ev_valid_in  = 1'b0;
      ev_pos_in    = iss_pos_ff;
      ev_pass_in   = iss_pass_ff;
      ev_last_in   = (iss_left_ff == CW'(1));
      res_frame_in = res_frame_ff;
      res_page_in  = res_page_ff;
      res_found_in = res_found_ff;
      res_wb_in    = res_wb_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_frame_in = rsp_frame_ff;
      rsp_page_in  = rsp_page_ff;
      rsp_found_in = rsp_found_ff;
      rsp_wb_in    = rsp_wb_ff;
      rsp_hand_in  = rsp_hand_ff;
      mem_we       = 1'b0;
      mem_waddr    = ev_pos_ff;
      mem_wdata    = ent;
      mem_raddr    = iss_pos_ff;

      // Configuration writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            clkpr_pkg::CSR_MODE:   mode_in = csr_data[0];
            clkpr_pkg::CSR_FRAMES: fiu_in  = csr_data;
            default:               mode_in = mode_ff;
         endcase
      end

      // Issue one frame read a cycle while scanning
      if ((state_ff == clkpr_pkg::ST_SCAN || state_ff == clkpr_pkg::ST_HAND) &&
          iss_left_ff != '0) begin
         ev_valid_in = 1'b1;
         iss_pos_in  = iss_pos_wrap;
         iss_idx_in  = iss_idx_wrap;
         iss_left_in = iss_left_ff - CW'(1);
         if (iss_idx_inc == n_ff) begin
            iss_pass_in = iss_pass_ff + 2'd1;
         end
      end

      unique case (state_ff)
         clkpr_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + FW'(1);
            if (clr_ff == FW'(FRAME_COUNT - 1)) begin
               state_in = clkpr_pkg::ST_IDLE;
            end
         end
         clkpr_pkg::ST_IDLE: begin
            if (req_beat) begin
               pid_in       = req_process_id;
               pid_ok_in    = req_pid_ok;
               n_in         = fiu_clamped;
               res_frame_in = '0;
               res_page_in  = '0;
               res_found_in = 1'b0;
               res_wb_in    = 1'b0;
               state_in     = clkpr_pkg::ST_FIN;
               if (req_kind == clkpr_pkg::KIND_WRITE) begin
                  if (32'(req_frame_index) < 32'(FRAME_COUNT)) begin
                     mem_we             = 1'b1;
                     mem_waddr          = req_frame_index;
                     mem_wdata.reserved = req_reserved_flag;
                     mem_wdata.owner    = req_process_id;
                     mem_wdata.valid    = req_page_valid;
                     mem_wdata.page     = req_page_number;
                     mem_wdata.present  = req_present_flag;
                     mem_wdata.used     = req_use_flag;
                     mem_wdata.dirty    = req_dirty_flag;
                  end
               end else if (req_kind == clkpr_pkg::KIND_HAND) begin
                  if (req_pid_ok) begin
                     hand_in[req_process_id] = req_frame_index;
                  end
               end else if (req_kind == clkpr_pkg::KIND_EVICT && req_pid_ok) begin
                  h_in     = hand_ff[req_process_id];
                  state_in = clkpr_pkg::ST_MOD;
               end
            end
         end
         clkpr_pkg::ST_MOD: begin
            // Reduce the hand below the scan length, then start the victim scan
            if (NW'(h_ff) >= n_ff) begin
               h_in = FW'(NW'(h_ff) - n_ff);
            end else begin
               iss_pos_in  = h_ff;
               iss_idx_in  = '0;
               iss_pass_in = 2'd0;
               iss_left_in = (mode_ff == clkpr_pkg::MODE_MODIFIED) ?
                             (CW'(n_ff) << 2) : (CW'(n_ff) << 1);
               state_in    = clkpr_pkg::ST_SCAN;
            end
         end
         clkpr_pkg::ST_SCAN: begin
            if (ev_valid_ff) begin
               if (take) begin
                  // Evict: drop present and use, then advance the hand from the next frame
                  mem_we            = 1'b1;
                  mem_wdata.present = 1'b0;
                  mem_wdata.used    = 1'b0;
                  res_frame_in      = ev_pos_ff;
                  res_page_in       = ent.page;
                  res_found_in      = 1'b1;
                  res_wb_in         = ent.dirty;
                  ev_valid_in       = 1'b0;
                  iss_pos_in        = ev_pos_wrap;
                  iss_idx_in        = '0;
                  iss_pass_in       = 2'd0;
                  iss_left_in       = CW'(n_ff) - CW'(1);
                  state_in          = clkpr_pkg::ST_HAND;
               end else begin
                  if (clear_use) begin
                     mem_we         = 1'b1;
                     mem_wdata.used = 1'b0;
                  end
                  if (ev_last_ff) begin
                     ev_valid_in = 1'b0;
                     state_in    = clkpr_pkg::ST_FIN;
                  end
               end
            end
         end
         clkpr_pkg::ST_HAND: begin
            if (ev_valid_ff && hand_hit) begin
               hand_in[pid_ff] = ev_pos_ff;
               ev_valid_in     = 1'b0;
               iss_left_in     = '0;
               state_in        = clkpr_pkg::ST_FIN;
            end else if ((ev_valid_ff && ev_last_ff) ||
                         (!ev_valid_ff && iss_left_ff == '0)) begin
               ev_valid_in = 1'b0;
               state_in    = clkpr_pkg::ST_FIN;
            end
         end
         clkpr_pkg::ST_FIN: begin
            // Hand the result to the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_frame_in = res_frame_ff;
               rsp_page_in  = res_page_ff;
               rsp_found_in = res_found_ff;
               rsp_wb_in    = res_wb_ff;
               rsp_hand_in  = pid_ok_ff ? hand_ff[pid_ff] : '0;
               state_in     = clkpr_pkg::ST_IDLE;
            end
         end
         default: state_in = clkpr_pkg::ST_IDLE;
      endcase
   end

   // Frame table port: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff    <= frame_mem[mem_raddr];
      fwd_hit_ff  <= mem_we && (mem_waddr == mem_raddr);
      fwd_data_ff <= mem_wdata;
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clkpr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= clkpr_pkg::MODE_CLOCK;
         fiu_ff       <= NW'(FIU_RESET);
         clr_ff       <= '0;
         iss_left_ff  <= '0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PROCESS_COUNT; i++) begin
            hand_ff[i] <= '0;
         end
      end else begin
         mode_ff      <= mode_in;
         fiu_ff       <= fiu_in;
         clr_ff       <= clr_in;
         iss_left_ff  <= iss_left_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hand_ff      <= hand_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      pid_ff       <= pid_in;
      pid_ok_ff    <= pid_ok_in;
      h_ff         <= h_in;
      iss_pos_ff   <= iss_pos_in;
      iss_idx_ff   <= iss_idx_in;
      iss_pass_ff  <= iss_pass_in;
      ev_pos_ff    <= ev_pos_in;
      ev_pass_ff   <= ev_pass_in;
      ev_last_ff   <= ev_last_in;
      res_frame_ff <= res_frame_in;
      res_page_ff  <= res_page_in;
      res_found_ff <= res_found_in;
      res_wb_ff    <= res_wb_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_page_ff  <= rsp_page_in;
      rsp_found_ff <= rsp_found_in;
      rsp_wb_ff    <= rsp_wb_in;
      rsp_hand_ff  <= rsp_hand_in;
   end

endmodule

// ----- hw/rtl/clkpr_checker.sv -----
module clkpr_checker #(
   parameter int FRAME_W = 6,
   parameter int PAGE_W  = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [FRAME_W-1:0] rsp_victim_frame,
   input logic [PAGE_W-1:0]  rsp_victim_page,
   input logic               rsp_victim_found,
   input logic               rsp_needs_writeback
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Stall requests while the table is swept after reset
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during table sweep");

   // Work on one item at a time
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // Report no victim as all-zero victim fields
   a_no_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_victim_found |->
         rsp_victim_frame == '0 && rsp_victim_page == '0 && !rsp_needs_writeback)
      else $error("victim fields set without a victim");

endmodule

bind clock_page_replacement_per_process_unit clkpr_checker #(
   .FRAME_W (FW),
   .PAGE_W  (PAGE_BITS)
) u_clkpr_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_victim_frame    (rsp_victim_frame),
   .rsp_victim_page     (rsp_victim_page),
   .rsp_victim_found    (rsp_victim_found),
   .rsp_needs_writeback (rsp_needs_writeback)
);
